// ===== design/assert_macros.svh =====
// Assertion helpers for the touch-hold qualifier design.
// THQ_ASSERT checks a property on every rising clock edge outside reset.
// THQ_ASSERT_ALWAYS checks a property on every rising clock edge, reset included.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define THQ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");
`define THQ_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");
`else
`define THQ_ASSERT(lbl, clk, rst_n, prop)
`define THQ_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== design/thq_pkg.sv =====
`timescale 1ns / 1ps

package thq_pkg;

    localparam int BASELINE_REGS    = 5;
    localparam int DEFAULT_CHANNELS = 5;
    localparam int HOLD_BITS        = 12;
    localparam int SAMPLE_W         = 16;
    localparam int TIME_W           = 32;
    localparam int SENS_W           = 9;
    localparam int Q_FRAC           = 8;
    localparam int PROD_W           = SAMPLE_W + SENS_W;
    localparam int THR_W            = PROD_W - Q_FRAC;
    localparam int HOLD_TABLE_W     = BASELINE_REGS * HOLD_BITS;
    localparam int CH_W             = 3;

    localparam int APB_ADDR_W = 6;
    localparam int APB_DATA_W = 64;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_BASELINE_FIRST = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_BASELINE_LAST  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SENS           = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_HOLD           = 3'd6;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_REARM  = 1'b1;

    localparam logic [SENS_W-1:0] SENS_RESET = 9'd205;
    // hold times 500, 500, 500, 600, 700 ms, channel 0 lowest
    localparam logic [HOLD_TABLE_W-1:0] HOLD_TABLE_RESET =
        {12'd700, 12'd600, 12'd500, 12'd500, 12'd500};

    typedef struct packed {
        logic [BASELINE_REGS-1:0][SAMPLE_W-1:0] baseline;
        logic [SENS_W-1:0]                      sens_q8;
        logic [HOLD_TABLE_W-1:0]                hold_table;
    } thq_cfg_t;

    typedef struct packed {
        logic                op;
        logic [CH_W-1:0]     ch;
        logic [SAMPLE_W-1:0] sample;
        logic [TIME_W-1:0]   now_ms;
        logic [THR_W-1:0]    thr;
    } thq_item_t;

endpackage

// ===== design/thq_apb_regs.sv =====
`timescale 1ns / 1ps

module thq_apb_regs (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  wr_en,
    input  logic [thq_pkg::REG_IDX_W-1:0]         reg_idx,
    input  logic [thq_pkg::APB_DATA_W-1:0]        wr_data,
    output logic [thq_pkg::APB_DATA_W-1:0]        rd_data,
    output thq_pkg::thq_cfg_t                     cfg
);

    thq_pkg::thq_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.baseline   <= '0;
            cfg_reg.sens_q8    <= thq_pkg::SENS_RESET;
            cfg_reg.hold_table <= thq_pkg::HOLD_TABLE_RESET;
        end else if (wr_en) begin
            case (reg_idx) inside
                [thq_pkg::REG_BASELINE_FIRST:thq_pkg::REG_BASELINE_LAST]: begin
                    cfg_reg.baseline[reg_idx] <= wr_data[thq_pkg::SAMPLE_W-1:0];
                end
                thq_pkg::REG_SENS: begin
                    cfg_reg.sens_q8 <= wr_data[thq_pkg::SENS_W-1:0];
                end
                thq_pkg::REG_HOLD: begin
                    cfg_reg.hold_table <= wr_data[thq_pkg::HOLD_TABLE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        rd_data = '0;
        case (reg_idx) inside
            [thq_pkg::REG_BASELINE_FIRST:thq_pkg::REG_BASELINE_LAST]: begin
                rd_data[thq_pkg::SAMPLE_W-1:0] = cfg_reg.baseline[reg_idx];
            end
            thq_pkg::REG_SENS: begin
                rd_data[thq_pkg::SENS_W-1:0] = cfg_reg.sens_q8;
            end
            thq_pkg::REG_HOLD: begin
                rd_data[thq_pkg::HOLD_TABLE_W-1:0] = cfg_reg.hold_table;
            end
            default: begin
                rd_data = '0;
            end
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/thq_qualify.sv =====
`timescale 1ns / 1ps

module thq_qualify #(
    parameter int CHANNELS = thq_pkg::DEFAULT_CHANNELS
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  fire,
    input  thq_pkg::thq_item_t                    item,
    input  logic [thq_pkg::HOLD_TABLE_W-1:0]      hold_table,
    output logic                                  touched_next
);

    localparam int ENTRIES = (CHANNELS < thq_pkg::BASELINE_REGS) ?
                             CHANNELS : thq_pkg::BASELINE_REGS;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int TW      = thq_pkg::TIME_W;

    logic [ENTRIES-1:0] armed_reg;
    logic [TW-1:0]      last_time_reg [ENTRIES];
    logic [TW-1:0]      held_reg      [ENTRIES];

    logic                          in_range;
    logic [IDX_W-1:0]              idx;
    logic                          cur_armed;
    logic [TW-1:0]                 cur_last;
    logic [TW-1:0]                 cur_held;
    logic [thq_pkg::HOLD_BITS-1:0] hold;
    logic [TW-1:0]                 delta;
    logic [TW:0]                   sum_wide;
    logic [TW-1:0]                 sum_sat;
    logic                          reach;
    logic                          contact;
    logic                          wr_en;
    logic                          armed_next;
    logic [TW-1:0]                 last_next;
    logic [TW-1:0]                 held_next;

    assign in_range = (int'(item.ch) < ENTRIES);
    assign idx      = item.ch[IDX_W-1:0];

    always_comb begin
        cur_armed = armed_reg[idx];
        cur_last  = last_time_reg[idx];
        cur_held  = held_reg[idx];
        hold      = hold_table[thq_pkg::HOLD_BITS*idx +: thq_pkg::HOLD_BITS];
        delta     = item.now_ms - cur_last;
        sum_wide  = {1'b0, cur_held} + {1'b0, delta};
        sum_sat   = sum_wide[TW] ? '1 : sum_wide[TW-1:0];
        reach     = (sum_sat >= {{(TW-thq_pkg::HOLD_BITS){1'b0}}, hold});
        contact   = ({1'b0, item.sample} < item.thr);
    end

    always_comb begin
        armed_next   = cur_armed;
        last_next    = cur_last;
        held_next    = cur_held;
        touched_next = 1'b0;
        if (in_range) begin
            if (item.op == thq_pkg::OP_REARM) begin
                armed_next = 1'b1;
            end else if (contact) begin
                if (cur_armed) begin
                    armed_next = 1'b0;
                    held_next  = '0;
                    last_next  = item.now_ms;
                end else if (reach) begin
                    held_next    = '0;
                    armed_next   = 1'b1;
                    touched_next = 1'b1;
                end else begin
                    held_next = sum_sat;
                    last_next = item.now_ms;
                end
            end else begin
                armed_next = 1'b1;
                held_next  = '0;
                last_next  = item.now_ms;
            end
        end
    end

    assign wr_en = fire && in_range;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg <= '1;
            for (int i = 0; i < ENTRIES; i++) begin
                last_time_reg[i] <= '0;
                held_reg[i]      <= '0;
            end
        end else if (wr_en) begin
            armed_reg[idx]     <= armed_next;
            last_time_reg[idx] <= last_next;
            held_reg[idx]      <= held_next;
        end
    end

endmodule

// ===== design/touch_hold_qualifier_unit.sv =====
`timescale 1ns / 1ps
// Channel  | Ports             | Payload
// ---------+-------------------+------------------------------------------------
// input    | s_tvalid/s_tready | s_tuser: operation, channel; s_tdata: sample, now_ms
// result   | m_tvalid/m_tready | m_tdata: touched
// config   | APB psel..pready  | baseline_ch0..4, sensitivity_q8, hold_time_table
//
// One item per cycle sustained while m_tready stays high. An accepted item
// reaches m_tvalid through the input register and then the result register.
// The input stage forms the channel threshold (baseline times sensitivity) into
// the input register; the decision stage reads the channel state, decides and
// loads the result register. Back-to-back items on one channel see each other's
// updates. Reset (aresetn low, synchronous) arms every channel and clears times
// and accumulators. A stalled result holds in the output register while one
// more item waits in the input register.

`include "assert_macros.svh"

module touch_hold_qualifier_unit #(
    parameter int CHANNELS = thq_pkg::DEFAULT_CHANNELS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input channel
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [47:0]                        s_tdata,  // [15:0] sample, [47:16] now_ms
    input  logic [3:0]                         s_tuser,  // [0] operation, [3:1] channel
    // result channel
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [7:0]                         m_tdata,  // [0] touched, [7:1] zero
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [thq_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [thq_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [thq_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);

    localparam int ENTRIES = (CHANNELS < thq_pkg::BASELINE_REGS) ?
                             CHANNELS : thq_pkg::BASELINE_REGS;

    thq_pkg::thq_cfg_t  cfg;
    thq_pkg::thq_item_t item_reg;
    thq_pkg::thq_item_t item_next;

    logic                          in_valid_reg;
    logic                          out_valid_reg;
    logic                          out_touched_reg;
    logic                          touched_next;
    logic                          advance;
    logic                          fire;
    logic                          s_accept;
    logic [thq_pkg::SAMPLE_W-1:0]  base_sel;
    logic [thq_pkg::PROD_W-1:0]    prod;
    logic [thq_pkg::CH_W-1:0]      s_ch;

    // Configuration port: no wait states.
    assign pready = 1'b1;

    thq_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (psel && penable && pwrite),
        .reg_idx (paddr[thq_pkg::APB_ADDR_W-1:3]),
        .wr_data (pwdata),
        .rd_data (prdata),
        .cfg     (cfg)
    );

    // Advance the decision stage whenever the result register is free or drains.
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    // Threshold: baseline times Q1.8 sensitivity, truncate the fraction.
    // Channels without a baseline register get zero here; the decision stage
    // keeps no state for them and reports no touch.
    assign s_ch     = s_tuser[3:1];
    assign base_sel = (int'(s_ch) < thq_pkg::BASELINE_REGS) ? cfg.baseline[s_ch] : '0;
    assign prod     = {{thq_pkg::SENS_W{1'b0}}, base_sel} *
                      {{thq_pkg::SAMPLE_W{1'b0}}, cfg.sens_q8};

    always_comb begin
        item_next.op     = s_tuser[0];
        item_next.ch     = s_ch;
        item_next.sample = s_tdata[15:0];
        item_next.now_ms = s_tdata[47:16];
        item_next.thr    = prod[thq_pkg::PROD_W-1:thq_pkg::Q_FRAC];
    end

    // Input register: load on accept, drop once handed to the decision stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg <= item_next;
        end
    end

    thq_qualify #(
        .CHANNELS (CHANNELS)
    ) u_qualify (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fire         (fire),
        .item         (item_reg),
        .hold_table   (cfg.hold_table),
        .touched_next (touched_next)
    );

    // Result register: hold while the sink stalls.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_touched_reg <= touched_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_touched_reg};

    // An empty result register never blocks the input side.
    `THQ_ASSERT(a_ready_when_empty, aclk, aresetn, !out_valid_reg |-> s_tready)
    // An item handed on shows up as a result in the next cycle.
    `THQ_ASSERT(a_fire_gives_result, aclk, aresetn, fire |=> out_valid_reg)
    // A report only comes from a sample on a channel that exists.
    `THQ_ASSERT(a_touch_only_sample, aclk, aresetn,
        touched_next |-> (item_reg.op == thq_pkg::OP_SAMPLE && int'(item_reg.ch) < ENTRIES))

endmodule
